// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/mmed_pkg.sv -----
package mmed_pkg;

	localparam int DEF_MAX_OUTPUT_POSITIONS = 16384;
	localparam int DEF_MAX_PENDING_EVENTS   = 62;

	localparam int SAMPLE_W = 16;
	localparam int HITS_W   = 4;
	localparam int POS_W    = 14;
	localparam int PEND_W   = 6;
	localparam int CNT_W    = 17;
	localparam int SPP_W    = 16;
	localparam int IDX_W    = 7;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = 2;

	// configuration register indexes
	localparam logic CFG_SPP  = 1'b0;
	localparam logic CFG_PASS = 1'b1;

	// result kinds
	localparam logic KIND_VALUE = 1'b0;
	localparam logic KIND_EVENT = 1'b1;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	// one accepted input that produces results
	typedef struct packed {
		logic [PEND_W-1:0]          n_events;
		logic                       pair;
		logic signed [SAMPLE_W-1:0] v0;
		logic signed [SAMPLE_W-1:0] v1;
		logic [POS_W-1:0]           pos0;
		logic [POS_W-1:0]           pos1;
	} cmd_t;

	function automatic logic [POS_W-1:0] pos_cap_f(input int max_pos);
		int c;
		c = max_pos - 1;
		if (c > (1 << POS_W) - 1) begin
			c = (1 << POS_W) - 1;
		end
		return POS_W'(c);
	endfunction

	function automatic logic [POS_W-1:0] pos_adv(input logic [POS_W-1:0] p,
			input logic [POS_W-1:0] cap);
		return (p < cap) ? p + 1'b1 : p;
	endfunction

endpackage

// ----- hw/rtl/min_max_envelope_decimator_top.sv -----
// Min/max envelope decimator for waveform display.
// Input queue side: present sample, event_hits and start_channel with push;
// a word is taken on a clock edge with push high and full low. Result queue
// side: while empty is low the oldest result is on kind/value/position/last;
// pop high takes it. last marks the final result of one input word.
// Configuration: cfg_index 0 = samples_per_pixel, 1 = pass_through, written
// when cfg_valid is high (cfg_ready is always high); write only while idle.
// Timing: one input word per cycle while full is low. A taken word's results
// pass through the command queue and the result register. The result stage
// emits one result per cycle while the receiver pops, so a word with k
// results (up to 62 marks plus one or two values) holds it until all are
// out; a four-entry command queue between the sample and result stages
// absorbs them and raises full when it fills; words with no result skip it.
// Reset: samples_per_pixel = 1, pass_through = 1, all running state cleared,
// queues empty. When the receiver stalls, the result is held, the command
// queue fills, and full then stalls the sender.
`include "assert_macros.svh"

module min_max_envelope_decimator_top #(
	parameter int MAX_OUTPUT_POSITIONS = mmed_pkg::DEF_MAX_OUTPUT_POSITIONS,
	parameter int MAX_PENDING_EVENTS   = mmed_pkg::DEF_MAX_PENDING_EVENTS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [mmed_pkg::SAMPLE_W-1:0] sample,
	input  logic [mmed_pkg::HITS_W-1:0]          event_hits,
	input  logic                                 start_channel,
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 kind,
	output logic signed [mmed_pkg::SAMPLE_W-1:0] value,
	output logic [mmed_pkg::POS_W-1:0]           position,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [mmed_pkg::SPP_W-1:0]           cfg_data
);
	import mmed_pkg::*;

	localparam logic [POS_W-1:0] PosCap = pos_cap_f(MAX_OUTPUT_POSITIONS);

	cmd_t cmd, head;
	logic cmd_valid, q_full, q_empty, q_pop;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	mmed_front #(
		.MAX_OUTPUT_POSITIONS(MAX_OUTPUT_POSITIONS),
		.MAX_PENDING_EVENTS  (MAX_PENDING_EVENTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.q_full       (q_full),
		.sample       (sample),
		.event_hits   (event_hits),
		.start_channel(start_channel),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd)
	);

	mmed_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_valid),
		.wr_data(cmd),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(head),
		.empty  (q_empty)
	);

	mmed_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.kind    (kind),
		.value   (value),
		.position(position),
		.last    (last)
	);

	`ASSERT_IMPLY(a_no_write_when_full, clk, arst_n, cmd_valid, !q_full, "command lost: queue full")
	`ASSERT_IMPLY(a_no_read_when_empty, clk, arst_n, q_pop, !q_empty, "dequeue from empty queue")
	`ASSERT_IMPLY(a_mark_value_zero, clk, arst_n, !empty && kind == KIND_EVENT, value == '0, "mark with nonzero value")
	`ASSERT_ALWAYS(a_pos_in_range, clk, arst_n, empty || position <= PosCap, "position above cap")

endmodule

// ----- hw/rtl/mmed_front.sv -----
module mmed_front #(
	parameter int MAX_OUTPUT_POSITIONS = mmed_pkg::DEF_MAX_OUTPUT_POSITIONS,
	parameter int MAX_PENDING_EVENTS   = mmed_pkg::DEF_MAX_PENDING_EVENTS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic                                 q_full,
	input  logic signed [mmed_pkg::SAMPLE_W-1:0] sample,
	input  logic [mmed_pkg::HITS_W-1:0]          event_hits,
	input  logic                                 start_channel,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_index,
	input  logic [mmed_pkg::SPP_W-1:0]           cfg_data,
	output logic                                 cmd_valid,
	output mmed_pkg::cmd_t                       cmd
);
	import mmed_pkg::*;

	localparam logic [POS_W-1:0]  PosCap  = pos_cap_f(MAX_OUTPUT_POSITIONS);
	localparam logic [PEND_W:0]   PendMax = (PEND_W + 1)'(MAX_PENDING_EVENTS);

	logic [SPP_W-1:0]           spp_q;
	logic                       pass_q;
	logic signed [SAMPLE_W-1:0] max_q, min_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [POS_W-1:0]           pos_q;
	logic [PEND_W-1:0]          pend_q;
	logic                       seen_q, closed_q;

	logic                       acc;
	logic                       closed_n;
	logic signed [SAMPLE_W-1:0] max0, min0, max1, min1;
	logic [CNT_W-1:0]           cnt0;
	logic [POS_W-1:0]           pos0, pos1;
	logic [PEND_W-1:0]          pend0, pend1;
	logic [PEND_W:0]            pend_sum;
	logic                       block_done;

	assign acc = push && !q_full;

	always_comb begin
		closed_n = start_channel ? seen_q : closed_q;
		cnt0     = start_channel ? '0 : cnt_q;
		pos0     = start_channel ? '0 : pos_q;
		pend0    = start_channel ? '0 : pend_q;
		max0     = start_channel ? SAMPLE_MIN : max_q;
		min0     = start_channel ? SAMPLE_MAX : min_q;
		pend_sum = {1'b0, pend0} + (PEND_W + 1)'(event_hits);
		if (closed_n) begin
			pend1 = pend0;
		end else if (pend_sum > PendMax) begin
			pend1 = PEND_W'(PendMax);
		end else begin
			pend1 = pend_sum[PEND_W-1:0];
		end
		max1       = (sample > max0) ? sample : max0;
		min1       = (sample < min0) ? sample : min0;
		pos1       = pos_adv(pos0, PosCap);
		block_done = (cnt0 == {spp_q, 1'b0});
	end

	always_comb begin
		cmd.n_events = pend1;
		cmd.pair     = !pass_q;
		cmd.v0       = pass_q ? sample : max1;
		cmd.v1       = min1;
		cmd.pos0     = pos0;
		cmd.pos1     = pos1;
		cmd_valid    = acc && (pass_q || block_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q  <= SPP_W'(1);
			pass_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SPP:  spp_q  <= cfg_data;
				CFG_PASS: pass_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= SAMPLE_MIN;
			min_q    <= SAMPLE_MAX;
			cnt_q    <= '0;
			pos_q    <= '0;
			pend_q   <= '0;
			seen_q   <= 1'b0;
			closed_q <= 1'b0;
		end else if (acc) begin
			seen_q   <= seen_q | start_channel;
			closed_q <= closed_n;
			if (pass_q) begin
				max_q  <= max0;
				min_q  <= min0;
				cnt_q  <= cnt0;
				pos_q  <= pos1;
				pend_q <= '0;
			end else if (block_done) begin
				max_q  <= SAMPLE_MIN;
				min_q  <= SAMPLE_MAX;
				cnt_q  <= CNT_W'(1);
				pos_q  <= pos_adv(pos1, PosCap);
				pend_q <= '0;
			end else begin
				max_q  <= max1;
				min_q  <= min1;
				cnt_q  <= cnt0 + 1'b1;
				pos_q  <= pos0;
				pend_q <= pend1;
			end
		end
	end

endmodule

// ----- hw/rtl/mmed_cmd_queue.sv -----
module mmed_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  mmed_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output mmed_pkg::cmd_t rd_data,
	output logic           empty
);
	import mmed_pkg::*;

	cmd_t             mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW:0] wr_ptr_q, rd_ptr_q;

	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[CMDQ_AW] != rd_ptr_q[CMDQ_AW]) &&
	                 (wr_ptr_q[CMDQ_AW-1:0] == rd_ptr_q[CMDQ_AW-1:0]);
	assign rd_data = mem_q[rd_ptr_q[CMDQ_AW-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wr_ptr_q[CMDQ_AW-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/mmed_back.sv -----
module mmed_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mmed_pkg::cmd_t                       head,
	input  logic                                 q_empty,
	output logic                                 q_pop,
	input  logic                                 pop,
	output logic                                 empty,
	output logic                                 kind,
	output logic signed [mmed_pkg::SAMPLE_W-1:0] value,
	output logic [mmed_pkg::POS_W-1:0]           position,
	output logic                                 last
);
	import mmed_pkg::*;

	logic [IDX_W-1:0]           idx_q;
	logic                       out_valid_q;
	logic                       kind_q, last_q;
	logic signed [SAMPLE_W-1:0] value_q;
	logic [POS_W-1:0]           position_q;

	logic [IDX_W-1:0]           n_ev;
	logic                       step, last_step;
	logic                       r_kind;
	logic signed [SAMPLE_W-1:0] r_value;
	logic [POS_W-1:0]           r_pos;

	// marks first, then one or two values
	always_comb begin
		n_ev      = IDX_W'(head.n_events);
		last_step = (idx_q == n_ev + IDX_W'(head.pair));
		step      = !q_empty && (!out_valid_q || pop);
		q_pop     = step && last_step;
		if (idx_q < n_ev) begin
			r_kind  = KIND_EVENT;
			r_value = '0;
			r_pos   = head.pos0;
		end else if (idx_q == n_ev) begin
			r_kind  = KIND_VALUE;
			r_value = head.v0;
			r_pos   = head.pos0;
		end else begin
			r_kind  = KIND_VALUE;
			r_value = head.v1;
			r_pos   = head.pos1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				idx_q       <= last_step ? '0 : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			kind_q     <= r_kind;
			value_q    <= r_value;
			position_q <= r_pos;
			last_q     <= last_step;
		end
	end

	assign empty    = !out_valid_q;
	assign kind     = kind_q;
	assign value    = value_q;
	assign position = position_q;
	assign last     = last_q;

endmodule

// ----- tb/sv/tb_min_max_envelope_decimator_top.sv -----
module tb_min_max_envelope_decimator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mmed_pkg::*;

	localparam int POS_LIMIT     = DEF_MAX_OUTPUT_POSITIONS;
	localparam int EVENT_LIMIT   = DEF_MAX_PENDING_EVENTS;
	localparam int POS_TOP_INT   = (POS_LIMIT - 1 < 16383) ? POS_LIMIT - 1 : 16383;
	localparam logic [POS_W-1:0] POS_TOP = POS_W'(POS_TOP_INT);
	localparam int SETTLE_CYCLES = 8;
	localparam int LIMIT         = 1000000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp;
		logic [HITS_W-1:0]          hits;
		logic                       st;
	} sample_word_t;

	typedef struct packed {
		logic                       kind;
		logic signed [SAMPLE_W-1:0] value;
		logic [POS_W-1:0]           position;
		logic                       last;
	} env_word_t;

	typedef enum int {POP_ALWAYS, POP_HALF, POP_RARE} pop_mode_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       push = 1'b0;
	logic                       full;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic [HITS_W-1:0]          event_hits = '0;
	logic                       start_channel = 1'b0;
	logic                       empty;
	logic                       pop = 1'b0;
	logic                       kind;
	logic signed [SAMPLE_W-1:0] value;
	logic [POS_W-1:0]           position;
	logic                       last;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic                       cfg_index = CFG_SPP;
	logic [SPP_W-1:0]           cfg_data = '0;

	min_max_envelope_decimator_top #(
		.MAX_OUTPUT_POSITIONS(POS_LIMIT),
		.MAX_PENDING_EVENTS(EVENT_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.event_hits(event_hits),
		.start_channel(start_channel),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.value(value),
		.position(position),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sample_word_t sample_q[$];
	env_word_t    expected_words[$];
	int           err_cnt = 0;

	// predictor copy of registers and running state
	logic [SPP_W-1:0]           spp_reg = 16'd1;
	logic                       pass_reg = 1'b1;
	logic signed [SAMPLE_W-1:0] env_max = SAMPLE_MIN;
	logic signed [SAMPLE_W-1:0] env_min = SAMPLE_MAX;
	logic [CNT_W-1:0]           blk_cnt = '0;
	logic [POS_W-1:0]           out_pos = '0;
	int                         pend_ev = 0;
	logic                       ch_seen = 1'b0;
	logic                       ev_closed = 1'b0;

	int        gap_left = 0;
	int        burst_left = 1;
	int        hold_left = 0;
	logic      hold_done = 1'b0;
	int        seg_left = 0;
	pop_mode_t stall_mode = POP_ALWAYS;
	int        cyc = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void reset_extremes();
		env_max = SAMPLE_MIN;
		env_min = SAMPLE_MAX;
	endfunction

	function automatic void add_result(input logic k, input logic signed [SAMPLE_W-1:0] v,
			input logic is_last);
		env_word_t w;
		w.kind = k;
		w.value = v;
		w.position = out_pos;
		w.last = is_last;
		expected_words.push_back(w);
	endfunction

	function automatic void step_pos();
		if (out_pos < POS_TOP) begin
			out_pos = out_pos + 1'b1;
		end
	endfunction

	function automatic void flush_events();
		for (int k = 0; k < pend_ev; k++) begin
			add_result(KIND_EVENT, '0, 1'b0);
		end
		pend_ev = 0;
	endfunction

	// expected results of one accepted sample word
	function automatic void decimate_word(input logic signed [SAMPLE_W-1:0] s,
			input logic [HITS_W-1:0] h, input logic st);
		logic [CNT_W-1:0] tgt;
		if (st) begin
			ev_closed = ch_seen;
			ch_seen = 1'b1;
			reset_extremes();
			blk_cnt = '0;
			out_pos = '0;
			pend_ev = 0;
		end
		if (!ev_closed) begin
			pend_ev = (pend_ev + int'(h) > EVENT_LIMIT) ? EVENT_LIMIT : pend_ev + int'(h);
		end
		if (pass_reg) begin
			flush_events();
			add_result(KIND_VALUE, s, 1'b1);
			step_pos();
		end else begin
			tgt = {spp_reg, 1'b0};
			if (s > env_max) begin
				env_max = s;
			end
			if (s < env_min) begin
				env_min = s;
			end
			if (blk_cnt == tgt) begin
				flush_events();
				add_result(KIND_VALUE, env_max, 1'b0);
				step_pos();
				add_result(KIND_VALUE, env_min, 1'b1);
				step_pos();
				blk_cnt = '0;
				reset_extremes();
			end
			blk_cnt = blk_cnt + 1'b1;
		end
	endfunction

	function automatic void field_check(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	// monitor: check result words, then predict for the accepted input word
	always @(posedge clk) begin
		env_word_t exp_w;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word: kind %0d value %0d position %0d last %0d",
						kind, value, position, last);
					err_cnt++;
				end else begin
					exp_w = expected_words.pop_front();
					field_check("kind", int'(exp_w.kind), int'(kind));
					field_check("value", int'(exp_w.value), int'(value));
					field_check("position", int'(exp_w.position), int'(position));
					field_check("last", int'(exp_w.last), int'(last));
				end
			end
			if (push && !full) begin
				decimate_word(sample, event_hits, start_channel);
				sample_q.delete(0);
			end
		end
	end

	// sender: bursts of offers with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (gap_left > 0) begin
			push <= 1'b0;
			gap_left--;
		end else if (sample_q.size() > 0) begin
			push <= 1'b1;
			sample <= sample_q[0].smp;
			event_hits <= sample_q[0].hits;
			start_channel <= sample_q[0].st;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
		end else begin
			push <= 1'b0;
		end
	end

	// receiver: stall pattern in segments, plus one long hold-off to back up the input
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left--;
		end else if (!hold_done && sample_q.size() > 100) begin
			hold_done = 1'b1;
			hold_left = 400;
			pop <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(10, 150);
				stall_mode = pop_mode_t'($urandom_range(0, 2));
			end else begin
				seg_left--;
			end
			case (stall_mode)
				POP_ALWAYS: begin
					pop <= 1'b1;
				end
				POP_HALF: begin
					pop <= 1'($urandom_range(0, 1));
				end
				default: begin
					pop <= ($urandom_range(0, 5) == 0);
				end
			endcase
		end
	end

	task automatic add_item(input logic signed [SAMPLE_W-1:0] s, input logic [HITS_W-1:0] h,
			input logic st);
		sample_word_t w;
		w.smp = s;
		w.hits = h;
		w.st = st;
		sample_q.push_back(w);
	endtask

	task automatic settle();
		while (sample_q.size() != 0 || expected_words.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [SPP_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		if (idx == CFG_SPP) begin
			spp_reg = data;
		end else begin
			pass_reg = data[0];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [HITS_W-1:0] rand_hits();
		case ($urandom_range(0, 5))
			0: return 4'd15;
			1, 2: return HITS_W'($urandom_range(1, 15));
			default: return '0;
		endcase
	endfunction

	task automatic run_phase(input logic [SPP_W-1:0] spp, input logic pass, input int n,
			input int start_div);
		logic st;
		write_reg(CFG_SPP, spp);
		write_reg(CFG_PASS, {{(SPP_W-1){1'b0}}, pass});
		for (int i = 0; i < n; i++) begin
			st = (start_div > 0) && ($urandom_range(0, start_div - 1) == 0);
			add_item(rand_sample(), rand_hits(), st);
		end
		settle();
	endtask

	initial begin
		while (cyc < LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("tb_min_max_envelope_decimator_top: done, errors");
		$finish;
	end

	initial begin
		logic [SPP_W-1:0] rnd_spp;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: pass-through; words before any channel start count as first channel
		add_item(SAMPLE_MAX, 4'd15, 1'b0);
		add_item(SAMPLE_MIN, 4'd0, 1'b0);
		add_item(16'sd0, 4'd1, 1'b0);
		add_item(16'sd1, 4'd15, 1'b1);
		add_item(-16'sd1, 4'd15, 1'b0);
		add_item(16'sh5555, 4'd8, 1'b0);
		settle();

		// switch to decimation mid-channel; events saturate, first block is one longer
		write_reg(CFG_SPP, 16'd2);
		write_reg(CFG_PASS, 16'd0);
		add_item(SAMPLE_MIN, 4'd15, 1'b0);
		add_item(SAMPLE_MAX, 4'd15, 1'b0);
		add_item(16'sd100, 4'd15, 1'b0);
		add_item(-16'sd100, 4'd15, 1'b0);
		add_item(16'shAAAA, 4'd15, 1'b0);
		add_item(16'sd7, 4'd0, 1'b0);
		add_item(16'sd8, 4'd2, 1'b0);
		add_item(16'sd9, 4'd0, 1'b0);
		settle();

		// longest block: partial block only, no output
		write_reg(CFG_SPP, 16'hFFFF);
		add_item(-16'sd5, 4'd0, 1'b0);
		add_item(SAMPLE_MAX, 4'd15, 1'b0);
		settle();

		// still first channel: events stay open, long pass-through run
		run_phase(16'd1, 1'b0, 60, 0);
		run_phase(16'd5, 1'b0, 60, 0);
		run_phase(16'd1, 1'b1, 200, 0);
		// later channels: events closed, trailing blocks dropped, zero spp wraps
		run_phase(16'd0, 1'b0, 40, 8);
		rnd_spp = SPP_W'($urandom_range(1, 8));
		run_phase(rnd_spp, 1'b0, 60, 16);
		run_phase(16'd3, 1'b1, 30, 10);

		settle();
		repeat (20) @(negedge clk);
		if (err_cnt == 0) begin
			$display("tb_min_max_envelope_decimator_top: done, clean");
		end else begin
			$display("tb_min_max_envelope_decimator_top: done, errors");
		end
		$finish;
	end

endmodule
